>>> sv/setc_pkg.sv
// shared types and constants for the scope edge trigger capture block
`default_nettype none

package setc_pkg;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 12;
  localparam int POS_W      = 7;
  localparam int TIDX_W     = 11;
  localparam int ROW_W      = 7;
  localparam int LEVEL_W    = 12;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // q16 scaling and screen geometry
  localparam int Q_FRAC     = 16;
  localparam int ROUND_HALF = 32768;
  localparam int ROW_CENTER = 64;
  localparam int ROW_MAX    = 127;

  // register reset values
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd2048;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd528;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    op_t  op;
    logic scan_en;
    logic rd_latch;
    logic rd_mul;
    logic rd_row;
    logic load_out;
    logic zero_win;
  } setc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } setc_status_t;

endpackage

`default_nettype wire

>>> sv/setc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module setc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/setc_ctrl.sv
// control state machine for the trigger capture block
`default_nettype none

module setc_ctrl
  import setc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [OP_W-1:0] operation,
  input  wire setc_status_t    status,
  output setc_cmd_t            cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_RD_DATA = 6'b000100,
    S_RD_MUL  = 6'b001000,
    S_RD_ROW  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = (state == S_IDLE);
    cmd        = '0;
    cmd.op     = op_t'(operation);
    cmd.accept = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          case (cmd.op)
            OP_FIND: state_next = S_SCAN;
            OP_READ: state_next = S_RD_DATA;
            default: begin
              // write or unused op: result is ready right away
              if (status.out_free) begin
                cmd.load_out = 1'b1;
                cmd.zero_win = 1'b1;
              end else begin
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_RD_DATA: begin
        cmd.rd_latch = 1'b1;
        state_next   = S_RD_MUL;
      end
      S_RD_MUL: begin
        cmd.rd_mul = 1'b1;
        state_next = S_RD_ROW;
      end
      S_RD_ROW: begin
        cmd.rd_row = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/setc_datapath.sv
// sample ring, trigger scan, row scaling and output register
`default_nettype none

module setc_datapath
  import setc_pkg::*;
#(
  parameter int RING_DEPTH   = 2048,
  parameter int WINDOW_WIDTH = 128,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire setc_cmd_t             cmd,
  output setc_status_t               status,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic [POS_W-1:0]      position,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TIDX_W-1:0]          trigger_index,
  output logic                       trigger_found,
  output logic [SAMPLE_W-1:0]        window_sample,
  output logic [ROW_W-1:0]           pixel_row
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int SW     = SAMPLE_BITS;
  localparam int CW     = SAMPLE_BITS + SAMPLE_W;
  localparam int CNT_W  = AW - 1;
  localparam int PROD_W = SCALE_W + LEVEL_W + 2;
  localparam int RMAG_W = PROD_W - Q_FRAC;
  localparam int RS_W   = RMAG_W + 2;
  localparam logic [AW-1:0]    HALF_W   = AW'((WINDOW_WIDTH / 2) % RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RING_DEPTH / 2 - 1);

  // configuration registers
  logic [LEVEL_W-1:0] level;
  logic [SCALE_W-1:0] scale;

  // ring bookkeeping and trigger state
  logic [AW-1:0] wp, wp_next;
  logic          full;
  logic [AW-1:0] trig_pos;
  logic          trig_hit;

  // scan state
  logic [AW-1:0]    scan_addr;
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_live;
  logic             have_newer;
  logic [SW-1:0]    newer_val;
  logic [AW-1:0]    newer_addr;

  // ram signals
  logic [AW-1:0] raddr, read_idx, rd_addr_q;
  logic          raddr_ok, entry_ok_q;
  logic [SW-1:0] rdata, rd_val;
  logic          ram_we;
  logic [SW+SAMPLE_W-1:0] wdata_ext;
  logic [SW-1:0]          wdata;

  // compare and scaling signals
  logic [CW-1:0]            newer_ext, rd_ext, level_ext;
  logic                     match;
  logic [SAMPLE_W+SW-1:0]   rd_trunc_ext;
  logic [SAMPLE_W-1:0]      res_sample;
  logic [ROW_W-1:0]         res_row, row_calc;
  logic signed [LEVEL_W:0]  offset;
  logic signed [PROD_W-1:0] prod_q, prod_next;
  logic [PROD_W-1:0]        mag, mag_rnd;
  logic [RMAG_W-1:0]        rmag;
  logic signed [RS_W-1:0]   row_s;
  logic [AW+TIDX_W-1:0]     tidx_ext;

  // ring write address and data
  assign wp_next   = wp + AW'(1);
  assign wdata_ext = {{SW{1'b0}}, sample};
  assign wdata     = wdata_ext[SW-1:0];
  assign ram_we    = cmd.accept && (cmd.op == OP_WRITE);

  // read address: scan walk or window entry
  assign read_idx = trig_pos - HALF_W + AW'(position);
  assign raddr    = cmd.scan_en ? scan_addr : read_idx;
  // entries 1..wp were written since reset, all once the ring has wrapped
  assign raddr_ok = full || ((raddr != '0) && (raddr <= wp));

  setc_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_next),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // unwritten entries read as zero
  assign rd_val = entry_ok_q ? rdata : '0;

  // rising crossing test between the held newer sample and the older one
  assign newer_ext = CW'(newer_val);
  assign rd_ext    = CW'(rd_val);
  assign level_ext = CW'(level);
  assign match     = (newer_ext >= level_ext) && (rd_ext < level_ext);

  always_comb begin
    status.out_free  = !out_valid || out_ready;
    status.scan_done = cmd.scan_en && rd_live && have_newer &&
                       (match || (scan_cnt == CNT_LAST));
  end

  // row scaling: offset times q16 scale, rounded half away from zero
  assign rd_trunc_ext = {{SAMPLE_W{1'b0}}, rd_val};
  assign offset    = $signed({1'b0, res_sample}) - $signed({1'b0, level});
  assign prod_next = PROD_W'($signed({1'b0, scale})) * PROD_W'(offset);
  assign mag       = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign mag_rnd   = mag + PROD_W'(ROUND_HALF);
  assign rmag      = mag_rnd[PROD_W-1:Q_FRAC];

  always_comb begin
    if (prod_q[PROD_W-1]) begin
      row_s = RS_W'(ROW_CENTER) + $signed({2'b00, rmag});
    end else begin
      row_s = RS_W'(ROW_CENTER) - $signed({2'b00, rmag});
    end
    if (row_s < 0) begin
      row_calc = '0;
    end else if (row_s > RS_W'(ROW_MAX)) begin
      row_calc = ROW_W'(ROW_MAX);
    end else begin
      row_calc = row_s[ROW_W-1:0];
    end
  end

  assign tidx_ext = {{TIDX_W{1'b0}}, trig_pos};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL: level <= cfg_data[LEVEL_W-1:0];
        REG_SCALE: scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // write pointer and wrap flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (ram_we) begin
      wp <= wp_next;
      if (wp_next == '0) begin
        full <= 1'b1;
      end
    end
  end

  // read pipeline tags
  always_ff @(posedge clk) begin
    rd_addr_q  <= raddr;
    entry_ok_q <= raddr_ok;
  end

  // trigger search walk
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_pos   <= '0;
      trig_hit   <= 1'b0;
      rd_live    <= 1'b0;
      have_newer <= 1'b0;
      scan_addr  <= '0;
      scan_cnt   <= '0;
    end else begin
      rd_live <= cmd.scan_en;
      if (cmd.accept && (cmd.op == OP_FIND)) begin
        scan_addr  <= wp - HALF_W;
        scan_cnt   <= '0;
        have_newer <= 1'b0;
        trig_pos   <= wp - HALF_W;
        trig_hit   <= 1'b0;
      end
      if (cmd.scan_en) begin
        scan_addr <= scan_addr - AW'(1);
        if (rd_live) begin
          have_newer <= 1'b1;
          if (have_newer) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
            if (match) begin
              trig_pos <= newer_addr;
              trig_hit <= 1'b1;
            end
          end
        end
      end
    end
  end

  // newer sample holding register
  always_ff @(posedge clk) begin
    if (cmd.scan_en && rd_live) begin
      newer_val  <= rd_val;
      newer_addr <= rd_addr_q;
    end
  end

  // window read result and scaling pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept && (cmd.op != OP_READ)) begin
      res_sample <= '0;
      res_row    <= '0;
    end
    if (cmd.rd_latch) begin
      res_sample <= rd_trunc_ext[SAMPLE_W-1:0];
    end
    if (cmd.rd_mul) begin
      prod_q <= prod_next;
    end
    if (cmd.rd_row) begin
      res_row <= row_calc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      trigger_index <= tidx_ext[TIDX_W-1:0];
      trigger_found <= trig_hit;
      window_sample <= cmd.zero_win ? '0 : res_sample;
      pixel_row     <= cmd.zero_win ? '0 : res_row;
    end
  end

endmodule

`default_nettype wire

>>> sv/scope_edge_trigger_capture.sv
// Rising-edge scope trigger with sample ring and window read-out.
// Sample write and unused op: result registered at the accept edge when the
// output is free, so writes stream at one per cycle. Window read: result
// goes through ram read, multiply, round and clamp stages, then waits for a
// free output. Find: one ring entry per cycle over the ram read port.
// Reset clears control and config; ring entries read as zero until written.
`default_nettype none

module scope_edge_trigger_capture
  import setc_pkg::*;
#(
  parameter int RING_DEPTH   = 2048,
  parameter int WINDOW_WIDTH = 128,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic [POS_W-1:0]      position,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TIDX_W-1:0]          trigger_index,
  output logic                       trigger_found,
  output logic [SAMPLE_W-1:0]        window_sample,
  output logic [ROW_W-1:0]           pixel_row,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  setc_cmd_t    cmd;
  setc_status_t status;

  // controller
  setc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  setc_datapath #(
    .RING_DEPTH   (RING_DEPTH),
    .WINDOW_WIDTH (WINDOW_WIDTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample        (sample),
    .position      (position),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_index (trigger_index),
    .trigger_found (trigger_found),
    .window_sample (window_sample),
    .pixel_row     (pixel_row)
  );

  // no new transaction is taken while the search walk runs
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en |-> !in_ready)
    else $error("input ready during trigger scan");

  // a result is only loaded into a free output register
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // out_valid rises only from a controller load
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid rose without a load");

endmodule

`default_nettype wire
